/* hdl/pip_pkg.sv */
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic inside_res;
    logic polygon_ok;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] vertex_count;
  } cfg_t;

  // query token walking down the cell row
  typedef struct packed {
    logic                      valid;
    logic                      has_prev;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
  } token_t;

endpackage

/* hdl/pip_if.sv */
interface pip_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/pip_edge.sv */
module pip_edge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [pip_pkg::COORD_W-1:0] px_i,
  input  logic signed [pip_pkg::COORD_W-1:0] py_i,
  input  logic signed [pip_pkg::COORD_W-1:0] xj_i,
  input  logic signed [pip_pkg::COORD_W-1:0] yj_i,
  input  logic signed [pip_pkg::COORD_W-1:0] xi_i,
  input  logic signed [pip_pkg::COORD_W-1:0] yi_i,
  output logic                               flip_o
);

  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;

  logic signed [DW-1:0] a_d, b_d, dy_d, e_d;
  logic signed [DW-1:0] a_q, b_q, dy_q, e_q;
  logic                 strad_d, strad1_q, strad2_q, strad3_q;
  logic                 v1_q, v2_q, v3_q, flip_q;
  logic signed [DW-1:0] b2_q, e2_q;
  logic                 dyneg2_q, dyneg3_q;
  logic signed [PW-1:0] p1_d, p2_d;
  logic signed [PW-1:0] p1_q, p1b_q, p2_q;
  logic        [PW:0]   diff;
  logic                 flip_d;

  // stage 1: differences and straddle test
  assign a_d     = {px_i[31], px_i} - {xi_i[31], xi_i};
  assign b_d     = {xj_i[31], xj_i} - {xi_i[31], xi_i};
  assign dy_d    = {yj_i[31], yj_i} - {yi_i[31], yi_i};
  assign e_d     = {py_i[31], py_i} - {yi_i[31], yi_i};
  assign strad_d = (yi_i > py_i) != (yj_i > py_i);

  // stages 2 and 3: one product each
  assign p1_d = a_q * dy_q;
  assign p2_d = b2_q * e2_q;

  // stage 4: sign of dy * (a*dy - b*e) decides the flip
  assign diff   = {p1b_q[PW-1], p1b_q} - {p2_q[PW-1], p2_q};
  assign flip_d = v3_q && strad3_q &&
                  (dyneg3_q ? (!diff[PW] && (|diff)) : diff[PW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      flip_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    dy_q     <= dy_d;
    e_q      <= e_d;
    strad1_q <= strad_d;

    p1_q     <= p1_d;
    b2_q     <= b_q;
    e2_q     <= e_q;
    dyneg2_q <= dy_q[DW-1];
    strad2_q <= strad1_q;

    p1b_q    <= p1_q;
    p2_q     <= p2_d;
    dyneg3_q <= dyneg2_q;
    strad3_q <= strad2_q;
  end

  assign flip_o = flip_q;

endmodule

/* hdl/pip_cell.sv */
module pip_cell #(
  parameter int Idx  = 0,
  parameter int CntW = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] wr_y_i,
  input  logic [CntW-1:0]                    n_i,
  input  pip_pkg::token_t                    tok_i,
  output pip_pkg::token_t                    tok_o,
  output logic                               flip_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic signed [pip_pkg::COORD_W-1:0] vx_q, vy_q;
  pip_pkg::token_t                    tok_d, tok_q;
  logic                               tok_valid_q;
  logic                               en;

  assign en = IdxC < n_i;

  always_comb begin
    tok_d = tok_i;
    if (en) begin
      tok_d.has_prev = 1'b1;
      tok_d.prev_x   = vx_q;
      tok_d.prev_y   = vy_q;
      if (!tok_i.has_prev) begin
        tok_d.first_x = vx_q;
        tok_d.first_y = vy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

  pip_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(tok_i.valid && tok_i.has_prev && en),
    .px_i   (tok_i.px),
    .py_i   (tok_i.py),
    .xj_i   (tok_i.prev_x),
    .yj_i   (tok_i.prev_y),
    .xi_i   (vx_q),
    .yi_i   (vy_q),
    .flip_o (flip_o)
  );

endmodule

/* hdl/point_in_polygon_test.sv */
// Query path: the query token steps through one vertex cell per cycle, plus a four-stage
// edge evaluation. A request is taken only in ST_IDLE, so one query finishes before the
// next is accepted; a vertex write leaves the block in ST_IDLE, and a query on fewer than
// three vertices goes straight to ST_FIN. A result left waiting holds off new requests.
// Reset clears vertex_count and all control; vertex storage is undefined until written.
module point_in_polygon_test #(
  parameter int MaxVertices = pip_pkg::MAX_VERTICES
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pip_if.sink    req_i,
  pip_if.source  rsp_o,
  pip_if.sink    cfg_i
);

  localparam int CntW  = $clog2(MaxVertices + 1);
  localparam int RunW  = $clog2(MaxVertices + 4);
  localparam logic [RunW-1:0] RunLast = RunW'(MaxVertices + 3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e                     state_q, state_d;
  logic [pip_pkg::CNT_W-1:0]  count_q;
  logic [CntW-1:0]            n_eff;
  logic                       ok_n;
  logic                       req_fire, query_fire, write_fire, rsp_fire;
  logic [RunW-1:0]            cnt_q, cnt_d;
  logic                       parity_q, parity_d;
  logic                       ok_q, ok_d;
  logic                       out_valid_q, out_valid_d;
  logic                       inside_q, inside_d;
  logic                       out_ok_q, out_ok_d;
  logic [MaxVertices:0]       flips;
  pip_pkg::token_t            tok [MaxVertices+1];

  assign n_eff = (32'(count_q) > 32'(MaxVertices)) ? CntW'(MaxVertices) : CntW'(count_q);
  assign ok_n  = n_eff >= CntW'(pip_pkg::MIN_VERTICES);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign query_fire  = req_fire && (req_i.data.req_type == pip_pkg::REQ_QUERY);
  assign write_fire  = req_fire && (req_i.data.req_type == pip_pkg::REQ_WRITE);
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data.vertex_count;
    end
  end

  // token entering the first cell
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = query_fire && ok_n;
    tok[0].px       = req_i.data.coord_x;
    tok[0].py       = req_i.data.coord_y;
  end

  for (genvar k = 0; k < MaxVertices; k++) begin : g_cell
    pip_cell #(
      .Idx (k),
      .CntW(CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_en_i(write_fire && (32'(req_i.data.vertex_index) == 32'(k))),
      .wr_x_i (req_i.data.coord_x),
      .wr_y_i (req_i.data.coord_y),
      .n_i    (n_eff),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .flip_o (flips[k])
    );
  end

  // closing edge: last used vertex back to vertex 0
  pip_edge u_close (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(tok[MaxVertices].valid && tok[MaxVertices].has_prev),
    .px_i   (tok[MaxVertices].px),
    .py_i   (tok[MaxVertices].py),
    .xj_i   (tok[MaxVertices].prev_x),
    .yj_i   (tok[MaxVertices].prev_y),
    .xi_i   (tok[MaxVertices].first_x),
    .yi_i   (tok[MaxVertices].first_y),
    .flip_o (flips[MaxVertices])
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    parity_d    = parity_q ^ (^flips);
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    out_ok_d    = out_ok_q;
    if (rsp_fire) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          ok_d     = ok_n;
          parity_d = 1'b0;
          cnt_d    = '0;
          state_d  = ok_n ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RunLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          inside_d    = parity_q & ok_q;
          out_ok_d    = ok_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      out_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ok_q        <= ok_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
      inside_q    <= inside_d;
      out_ok_q    <= out_ok_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.data.inside_res = inside_q;
  assign rsp_o.data.polygon_ok = out_ok_q;

  // no edge may report a crossing while no query is in flight
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (flips == '0))
    else $error("edge flip while idle");

  a_short_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.data.polygon_ok) |-> !rsp_o.data.inside_res)
    else $error("inside reported for short polygon");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_fire && ok_n) |-> ##(MaxVertices + 5) (state_q == ST_FIN))
    else $error("query walk length mismatch");

endmodule
